// File: rtl/acv_pkg.sv
// Shared types and constants of the block autocovariance accumulator.
`timescale 1ns / 1ps
package acv_pkg;
   localparam int SAMPLE_W   = 8;
   localparam int PASS_W     = 11;
   localparam int MEAN_W     = 16;
   localparam int LAG_W      = 6;
   localparam int COV_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ADDR_W     = 7;

   localparam logic [CSR_IDX_W-1:0] IDX_NUM_PASSES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_MEAN_Q8    = 2'd1;

   localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

   // Configuration as seen by the rest of the block.
   typedef struct packed {
      logic [PASS_W-1:0] num_passes;
      logic [MEAN_W-1:0] mean_q8;
   } cfg_type;

   // One entry of the queue between front and back.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]   addr;
      logic                last;
      logic                emit;
      logic [PASS_W-1:0]   passes;
   } entry_type;
endpackage

// File: rtl/acv_if.sv
// Handshake channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps
interface acv_req_if;
   import acv_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface acv_rsp_if;
   import acv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [LAG_W-1:0] lag;
   logic [COV_W-1:0]        abs_covariance;
   logic                    last_of_run;
   modport source (output valid, output lag, output abs_covariance, output last_of_run,
                   input ready);
   modport sink (input valid, input lag, input abs_covariance, input last_of_run,
                 output ready);
endinterface

interface acv_csr_if;
   import acv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/acv_front.sv
// Front end: registers, sample counting, pass tracking and item classification.
`timescale 1ns / 1ps
module acv_front #(
   parameter int BLOCK_SIZE = 128,
   parameter int MAX_PASSES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   acv_req_if.sink            req_ch,
   acv_csr_if.sink            csr_ch,
   input  logic               q_full,
   output logic               push,
   output acv_pkg::entry_type push_entry,
   output acv_pkg::cfg_type   cfg
);
   import acv_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_SIZE);

   logic [PASS_W-1:0] num_passes_ff, num_passes_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              finished_ff, finished_in;
   logic [PASS_W-1:0] eff_passes;
   logic              take, live, block_end, last_pass;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;
   assign take = req_ch.valid && !q_full;

   always_comb begin
      if (32'(num_passes_ff) > MAX_PASSES) begin
         eff_passes = PASS_W'(MAX_PASSES);
      end else begin
         eff_passes = num_passes_ff;
      end
   end

   assign live      = !finished_ff && (pass_ff <= eff_passes);
   assign block_end = (count_ff == CNT_W'(BLOCK_SIZE - 1));
   assign last_pass = (pass_ff == eff_passes);
   assign push      = take && live;

   always_comb begin
      push_entry.sample = req_ch.sample;
      push_entry.addr   = ADDR_W'(count_ff);
      push_entry.last   = block_end;
      push_entry.emit   = block_end && last_pass;
      push_entry.passes = pass_ff;
   end

   assign cfg.num_passes = num_passes_ff;
   assign cfg.mean_q8    = mean_ff;

   always_comb begin
      num_passes_in = num_passes_ff;
      mean_in       = mean_ff;
      count_in      = count_ff;
      pass_in       = pass_ff;
      finished_in   = finished_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == IDX_NUM_PASSES) begin
            num_passes_in = csr_ch.data[PASS_W-1:0];
         end else if (csr_ch.index == IDX_MEAN_Q8) begin
            mean_in = csr_ch.data;
         end
      end
      if (push) begin
         if (block_end) begin
            count_in = '0;
            if (last_pass) begin
               finished_in = 1'b1;
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_passes_ff <= PASS_W'(1);
         mean_ff       <= '0;
         count_ff      <= '0;
         pass_ff       <= PASS_W'(1);
         finished_ff   <= 1'b0;
      end else begin
         num_passes_ff <= num_passes_in;
         mean_ff       <= mean_in;
         count_ff      <= count_in;
         pass_ff       <= pass_in;
         finished_ff   <= finished_in;
      end
   end
endmodule

// File: rtl/acv_queue.sv
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module acv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  acv_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output acv_pkg::entry_type head
);
   import acv_pkg::*;

   entry_type  slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if ((fill_ff == 2'd0) || (pop && fill_ff == 2'd1)) begin
            slot0_in = push_entry;
         end else begin
            slot1_in = push_entry;
         end
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end
endmodule

// File: rtl/acv_back.sv
// Back end: sample store, lag multiply-accumulate sweep and result computation.
`timescale 1ns / 1ps
module acv_back #(
   parameter int BLOCK_SIZE = 128,
   parameter int MAX_PASSES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  acv_pkg::entry_type q_head,
   output logic               pop,
   input  logic [acv_pkg::MEAN_W-1:0] mean_q8,
   acv_rsp_if.source          rsp_ch
);
   import acv_pkg::*;

   localparam int HALF    = BLOCK_SIZE / 2;
   localparam int QUARTER = BLOCK_SIZE / 4;
   localparam int SA_W    = $clog2(BLOCK_SIZE);
   localparam int J_W     = $clog2(HALF);
   localparam int SUM_W   = 2 * SAMPLE_W + $clog2(HALF) + $clog2(MAX_PASSES + 1);
   localparam int DEN_W   = PASS_W + $clog2(HALF + 1);
   localparam int A_W     = SUM_W + 16;
   localparam int B_W     = 2 * MEAN_W + DEN_W;
   localparam int CW      = (A_W > B_W) ? A_W : B_W;
   localparam int QW      = CW - 8;
   localparam int DC_W    = $clog2(QW + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MAC   = 4'd1;
   localparam logic [3:0] ST_DRAIN = 4'd2;
   localparam logic [3:0] ST_ERD   = 4'd3;
   localparam logic [3:0] ST_EMUL  = 4'd4;
   localparam logic [3:0] ST_EDIFF = 4'd5;
   localparam logic [3:0] ST_EDIV  = 4'd6;
   localparam logic [3:0] ST_EFIN  = 4'd7;
   localparam logic [3:0] ST_EOUT  = 4'd8;

   logic [SAMPLE_W-1:0] store_mem [BLOCK_SIZE];
   logic [SUM_W-1:0]    lag_mem [HALF];
   logic [HALF-1:0]     lag_vld_ff;

   logic [3:0]          state_ff;
   logic [J_W-1:0]      j_ff, i_ff;
   logic                emit_ff;
   logic [PASS_W-1:0]   passes_ff;
   logic [SAMPLE_W-1:0] da_ff, db_ff;
   logic                s1_ff, s2_ff;
   logic [2*SAMPLE_W-1:0] prod_ff;
   logic [SUM_W-1:0]    acc_ff;
   logic [SUM_W-1:0]    lag_rd_ff;
   logic                lag_rd_vld_ff;
   logic [2*MEAN_W-1:0] mm_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [CW-1:0]       a_ff, b_ff;
   logic [QW-1:0]       quot_ff;
   logic [DEN_W:0]      rem_ff;
   logic [DC_W-1:0]     dcnt_ff;
   logic                rsp_valid_ff;
   logic [LAG_W-1:0]    rsp_lag_ff;
   logic [COV_W-1:0]    rsp_cov_ff;
   logic                rsp_last_ff;
   logic [DEN_W:0]      rem_shift;
   logic                lag_end;
   logic [CW-1:0]       diff;

   assign pop     = (state_ff == ST_IDLE) && q_not_empty;
   assign lag_end = (j_ff == J_W'(HALF - 1));
   assign rem_shift = {rem_ff[DEN_W-1:0], quot_ff[QW-1]};
   assign diff = (a_ff >= b_ff) ? (a_ff - b_ff) : (b_ff - a_ff);

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.lag            = rsp_lag_ff;
   assign rsp_ch.abs_covariance = rsp_cov_ff;
   assign rsp_ch.last_of_run    = rsp_last_ff;

   // Memories: the sample store has two registered read ports, the lag sums one.
   always_ff @(posedge clock) begin
      if (pop) begin
         store_mem[q_head.addr[SA_W-1:0]] <= q_head.sample;
      end
      da_ff <= store_mem[SA_W'(j_ff) + SA_W'(i_ff)];
      db_ff <= store_mem[SA_W'(QUARTER) + SA_W'(i_ff)];
      lag_rd_ff <= lag_mem[j_ff];
      if ((state_ff == ST_DRAIN) && !s1_ff && !s2_ff) begin
         lag_mem[j_ff] <= acc_ff + (lag_rd_vld_ff ? lag_rd_ff : SUM_W'(0));
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lag_rd_vld_ff <= lag_vld_ff[j_ff];
      prod_ff <= da_ff * db_ff;
      if (state_ff == ST_IDLE) begin
         acc_ff <= '0;
      end else if (s2_ff) begin
         acc_ff <= acc_ff + SUM_W'(prod_ff);
      end else if (state_ff == ST_DRAIN && !s1_ff) begin
         acc_ff <= '0;
      end
      if (pop && q_head.last) begin
         emit_ff   <= q_head.emit;
         passes_ff <= q_head.passes;
      end
      if (state_ff == ST_ERD) begin
         mm_ff  <= (2*MEAN_W)'(mean_q8) * (2*MEAN_W)'(mean_q8);
         den_ff <= DEN_W'(passes_ff) * DEN_W'(HALF);
      end
      if (state_ff == ST_EMUL) begin
         a_ff <= CW'(lag_rd_vld_ff ? lag_rd_ff : SUM_W'(0)) << 16;
         b_ff <= CW'(mm_ff) * CW'(den_ff);
      end
      if (state_ff == ST_EDIFF) begin
         quot_ff <= diff[CW-1:8];
         rem_ff  <= '0;
      end else if (state_ff == ST_EDIV) begin
         if (rem_shift >= (DEN_W+1)'(den_ff)) begin
            rem_ff  <= rem_shift - (DEN_W+1)'(den_ff);
            quot_ff <= {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            quot_ff <= {quot_ff[QW-2:0], 1'b0};
         end
      end
      if (state_ff == ST_EFIN) begin
         rsp_lag_ff  <= LAG_W'(32'(j_ff) - QUARTER);
         rsp_cov_ff  <= (quot_ff > QW'(COV_MAX)) ? COV_MAX : quot_ff[COV_W-1:0];
         rsp_last_ff <= lag_end;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         i_ff         <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         lag_vld_ff   <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff <= (state_ff == ST_MAC);
         s2_ff <= s1_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (pop && q_head.last) begin
                  j_ff     <= '0;
                  i_ff     <= '0;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (i_ff == J_W'(HALF - 1)) begin
                  i_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!s1_ff && !s2_ff) begin
                  lag_vld_ff[j_ff] <= 1'b1;
                  if (lag_end) begin
                     j_ff     <= '0;
                     state_ff <= emit_ff ? ST_ERD : ST_IDLE;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_MAC;
                  end
               end
            end
            ST_ERD:   state_ff <= ST_EMUL;
            ST_EMUL:  state_ff <= ST_EDIFF;
            ST_EDIFF: begin
               dcnt_ff  <= '0;
               state_ff <= ST_EDIV;
            end
            ST_EDIV: begin
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DC_W'(QW - 1)) begin
                  state_ff <= ST_EFIN;
               end
            end
            ST_EFIN: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EOUT;
            end
            ST_EOUT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (lag_end) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_ERD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_rsp_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EOUT))
      else $error("result valid outside the output state");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch.ready && rsp_last_ff) |=> (state_ff == ST_IDLE))
      else $error("run did not end after its last result");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDIV) |-> (dcnt_ff < DC_W'(QW)))
      else $error("divider ran past its width");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (s1_ff || s2_ff) |-> !pop)
      else $error("sample store written during the lag sweep");
`endif
endmodule

// File: rtl/block_autocovariance_accumulator.sv
// Top level of the block autocovariance accumulator.
`timescale 1ns / 1ps
// Samples are taken at one item per cycle into a two-entry queue and written
// into a sample store. When the last sample of a block arrives, a single
// multiply-accumulate unit sweeps every lag, one product per cycle inside
// each lag, so input stalls during the sweep after each block once the queue
// has filled; within a block the rate is one item per cycle. After the final
// pass each lag is turned into a result by a bit-serial divider, and each
// result item waits for the sink to accept it before the next lag starts.
// Once the run is emitted all further samples are accepted and discarded
// until reset. No clearing pass follows reset: lag sums carry valid bits.
module block_autocovariance_accumulator #(
   parameter int BLOCK_SIZE = 128,
   parameter int MAX_PASSES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   acv_req_if.sink    req_ch,
   acv_rsp_if.source  rsp_ch,
   acv_csr_if.sink    csr_ch
);
   import acv_pkg::*;

   logic      push, q_full, q_not_empty, pop;
   entry_type push_entry, q_head;
   cfg_type   cfg;

   // Front end classifies each sample and holds the configuration registers.
   acv_front #(.BLOCK_SIZE(BLOCK_SIZE), .MAX_PASSES(MAX_PASSES)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .csr_ch(csr_ch),
      .q_full(q_full), .push(push), .push_entry(push_entry), .cfg(cfg)
   );

   // The queue lets the front keep taking samples while the back is busy.
   acv_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .full(q_full), .pop(pop), .not_empty(q_not_empty), .head(q_head)
   );

   // Back end owns the stores and produces the result items.
   acv_back #(.BLOCK_SIZE(BLOCK_SIZE), .MAX_PASSES(MAX_PASSES)) u_back (
      .clock(clock), .reset(reset), .q_not_empty(q_not_empty), .q_head(q_head),
      .pop(pop), .mean_q8(cfg.mean_q8), .rsp_ch(rsp_ch)
   );
endmodule

// File: tb/acv_covariance_checker.sv
// Checker that predicts the lag covariance run and compares it with the result channel.
`timescale 1ns / 1ps
module acv_covariance_checker #(
   parameter int BLOCK_SIZE = 128,
   parameter int MAX_PASSES = 1024
) (
   input  logic clock,
   input  logic reset,
   acv_req_if   req_ch,
   acv_rsp_if   rsp_ch,
   acv_csr_if   csr_ch,
   output int   fail_count,
   output int   pending_results,
   output int   results_checked
);
   import acv_pkg::*;

   localparam int HALF    = BLOCK_SIZE / 2;
   localparam int QUARTER = BLOCK_SIZE / 4;

   typedef struct packed {
      logic signed [LAG_W-1:0] lag;
      logic [COV_W-1:0]        cov;
      logic                    last;
   } lag_result_type;

   logic [PASS_W-1:0]   passes_reg;
   logic [MEAN_W-1:0]   mean_reg;
   logic [SAMPLE_W-1:0] block_samples [BLOCK_SIZE];
   logic [63:0]         lag_totals [HALF];
   int                  fill_pos;
   int                  pass_no;
   logic                run_done;
   lag_result_type      expected_lags [$];
   int                  mismatches;
   int                  checked;
   int                  pending_count;

   assign fail_count      = mismatches;
   assign pending_results = pending_count;
   assign results_checked = checked;

   function automatic int passes_in_force();
      return (passes_reg > MAX_PASSES) ? MAX_PASSES : int'(passes_reg);
   endfunction

   // Magnitude of the averaged sum less the squared mean, in Q16.8.
   function automatic logic [COV_W-1:0] lag_covariance(logic [63:0] total, int passes);
      logic [63:0] scaled, mean_sq, diff, quot;
      scaled  = total << 16;
      mean_sq = 64'(mean_reg) * 64'(mean_reg) * 64'(passes) * 64'(HALF);
      diff    = (scaled >= mean_sq) ? scaled - mean_sq : mean_sq - scaled;
      quot    = diff / (64'(passes) * 64'(HALF) * 64'd256);
      return (quot > 64'(COV_MAX)) ? COV_MAX : quot[COV_W-1:0];
   endfunction

   task automatic take_sample(logic [SAMPLE_W-1:0] value);
      logic [63:0] acc;
      lag_result_type r;
      if (run_done || pass_no > passes_in_force()) return;
      block_samples[fill_pos] = value;
      fill_pos++;
      if (fill_pos < BLOCK_SIZE) return;
      fill_pos = 0;
      for (int j = 0; j < HALF; j++) begin
         acc = 0;
         for (int i = 0; i < HALF; i++)
            acc += 64'(block_samples[j+i]) * 64'(block_samples[QUARTER+i]);
         lag_totals[j] += acc;
      end
      if (pass_no != passes_in_force()) begin
         pass_no++;
         return;
      end
      for (int j = 0; j < HALF; j++) begin
         r.lag  = LAG_W'(j - HALF / 2);
         r.cov  = lag_covariance(lag_totals[j], pass_no);
         r.last = (j == HALF - 1);
         expected_lags.push_back(r);
      end
      run_done = 1'b1;
   endtask

   task automatic check_result();
      lag_result_type want;
      if (expected_lags.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result lag %0d cov %0d last %0b", $realtime,
                     rsp_ch.lag, rsp_ch.abs_covariance, rsp_ch.last_of_run);
         return;
      end
      want = expected_lags.pop_front();
      checked++;
      if (rsp_ch.lag !== want.lag || rsp_ch.abs_covariance !== want.cov ||
          rsp_ch.last_of_run !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"%0t: mismatch expected lag %0d cov %0d last %0b, ",
                      "got lag %0d cov %0d last %0b"},
                     $realtime, want.lag, want.cov, want.last, rsp_ch.lag,
                     rsp_ch.abs_covariance, rsp_ch.last_of_run);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         passes_reg = 1;
         mean_reg   = 0;
         fill_pos   = 0;
         pass_no    = 1;
         run_done   = 1'b0;
         for (int j = 0; j < HALF; j++) lag_totals[j] = 0;
         expected_lags.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == IDX_NUM_PASSES) passes_reg = csr_ch.data[PASS_W-1:0];
            else if (csr_ch.index == IDX_MEAN_Q8) mean_reg = csr_ch.data[MEAN_W-1:0];
         end
         if (req_ch.valid && req_ch.ready) take_sample(req_ch.sample);
         if (rsp_ch.valid && rsp_ch.ready) check_result();
      end
      pending_count = expected_lags.size();
   end

   initial begin
      mismatches    = 0;
      checked       = 0;
      pending_count = 0;
   end
endmodule

// File: tb/tb_block_autocovariance_accumulator.sv
// Testbench top: stimulus, result back-pressure and verdict for the accumulator.
`timescale 1ns / 1ps
module tb_block_autocovariance_accumulator;
   import acv_pkg::*;

   // The block sweeps every lag after each block of samples, so a gap of this
   // many cycles covers the sweep before a register is touched again.
   localparam int SWEEP_CYCLES = 5000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int EARLY_COUNT  = 40;

   // Register indexes that the block does not decode.
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = 2'd3;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_results;
   int   results_checked;
   int   samples_sent;
   int   burst_left;
   int   hold_left;
   logic hold_done;

   acv_req_if req_ch ();
   acv_rsp_if rsp_ch ();
   acv_csr_if csr_ch ();

   block_autocovariance_accumulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   acv_covariance_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A hard limit on the run, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("block_autocovariance_accumulator regression: fail");
      $finish;
   end

   // Mostly short gaps, a few long ones, and bursts with no gaps at all.
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 70) return $urandom_range(0, 1);
      if (roll < 95) return $urandom_range(2, 6);
      return $urandom_range(15, 40);
   endfunction

   // Offers one register write and holds it until the block takes it.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Offers one sample item after a random gap; valid stays high for the next
   // item when no gap follows, so it is never lowered and raised in one step.
   task automatic send_sample(logic [SAMPLE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.sample = value;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // Sends the samples of one block from position k_lo up to but not including k_hi.
   task automatic send_block(int directed, int k_lo, int k_hi);
      logic [SAMPLE_W-1:0] edge_values [8];
      edge_values = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F};
      for (int k = k_lo; k < k_hi; k++) begin
         if (directed && k < 8) send_sample(edge_values[k]);
         else if (directed && k < 16) send_sample(8'hFF);
         else send_sample(8'($urandom_range(0, 255)));
      end
      req_ch.valid = 1'b0;
   endtask

   // Result side: random stalls, plus one long hold once the first result shows.
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_ch.valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 9) < 7) ||
                           ($urandom_range(0, 19) == 0 && rsp_ch.ready);
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] final_mean;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = '0;
      csr_ch.data   = '0;
      samples_sent  = 0;
      burst_left    = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Zero passes: every sample is dropped. Writes to unused indexes are
      // ignored, and the mean takes its widest value for now.
      write_reg(IDX_NUM_PASSES, 16'd0);
      write_reg(IDX_MEAN_Q8, 16'hFFFF);
      write_reg(IDX_SPARE_LO, 16'hFFFF);
      write_reg(IDX_SPARE_HI, 16'h1234);
      for (int k = 0; k < 5; k++) send_sample(8'($urandom_range(0, 255)));
      req_ch.valid = 1'b0;
      repeat (20) @(negedge clock);

      // Pass count above the maximum saturates, so the first block only
      // accumulates; the extreme samples sit at its head. The next block
      // starts at once, so its first samples wait out the sweep, the queue
      // fills and the input stalls.
      write_reg(IDX_NUM_PASSES, 16'h07FF);
      write_reg(IDX_MEAN_Q8, 16'd65280);
      send_block(1, 0, 128);
      send_block(0, 0, EARLY_COUNT);
      repeat (SWEEP_CYCLES) @(negedge clock);

      // Lowering the pass count to two makes the block under way the last one.
      // The mean is only applied at emission, so its last value counts.
      write_reg(IDX_NUM_PASSES, 16'd2);
      write_reg(IDX_MEAN_Q8, 16'd0);
      case ($urandom_range(0, 2))
         0: final_mean = 16'hFFFF;
         1: final_mean = 16'd65280;
         default: final_mean = 16'($urandom_range(0, 65535));
      endcase
      write_reg(IDX_MEAN_Q8, final_mean);
      send_block(0, EARLY_COUNT, 128);

      // Samples after the final pass are taken and dropped while the final
      // sweep runs.
      for (int k = 0; k < 12; k++) send_sample(8'($urandom_range(0, 255)));
      req_ch.valid = 1'b0;

      wait (pending_results == 0 && hold_done);
      repeat (200) @(negedge clock);

      $display("Sent %0d sample items over three phases (mean 0x%04h at emission),",
               samples_sent, final_mean);
      $display("checked %0d lag results, %0d mismatches.", results_checked, fail_count);
      if (fail_count == 0)
         $display("block_autocovariance_accumulator regression: pass");
      else
         $display("block_autocovariance_accumulator regression: fail");
      $finish;
   end
endmodule

// File: sim.f
rtl/acv_pkg.sv
rtl/acv_if.sv
rtl/acv_front.sv
rtl/acv_queue.sv
rtl/acv_back.sv
rtl/block_autocovariance_accumulator.sv
tb/acv_covariance_checker.sv
tb/tb_block_autocovariance_accumulator.sv
